@@ hdl/tla_pkg.sv @@
// Package for the two-locus ANOVA F statistic block.
// Holds shared widths, limits, register indexes and the back-end state type.
// No dependencies.
package tla_pkg;

   localparam int DEF_MAX_SAMPLES = 4096;
   localparam int DEF_PHENO_WIDTH = 16;

   localparam int NUM_GROUPS = 4;
   localparam int GRPW       = 2;

   // configuration register file
   localparam int REGW = 44;
   localparam int CSRIW = 1;
   localparam logic [CSRIW-1:0] CSR_TOTAL_SS = 1'b0;
   localparam logic [CSRIW-1:0] CSR_MEAN_CORR = 1'b1;

   // group term sum saturates at 2^46
   localparam int RAWW = 47;
   localparam logic [RAWW-1:0] SSB_LIMIT = 47'h4000_0000_0000;

   localparam int SSBW  = 49;   // raw minus mean correction, signed
   localparam int DENDW = 50;   // total SS minus SSB, signed
   localparam int SMW   = 47;   // magnitudes of the two above
   localparam int DENW  = 49;   // df_between times denominator magnitude

   // result fields
   localparam int FRACW  = 16;
   localparam int FW     = 32;
   localparam int DFBW   = 2;
   localparam int DFWW   = 13;
   localparam int DFW_MAX = 8191;
   localparam int RSPW   = 48;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GROUP,
      ST_MUL,
      ST_DIVLD,
      ST_DIV,
      ST_ACC,
      ST_SSB,
      ST_RATIO,
      ST_SIGN,
      ST_DEN,
      ST_SATCK,
      ST_FINAL,
      ST_EMIT
   } back_state_type;

endpackage

@@ hdl/tla_front.sv @@
// Front end: accepts samples and accumulates per-group sums and counts.
// On a last sample it pushes a snapshot of the totals and clears. Uses tla_pkg.
module tla_front #(
   parameter int MAX_SAMPLES = tla_pkg::DEF_MAX_SAMPLES,
   parameter int PHENO_WIDTH = tla_pkg::DEF_PHENO_WIDTH,
   parameter int INW   = ((PHENO_WIDTH + 2 + 7) / 8) * 8,
   parameter int SNAPW = 4 * (PHENO_WIDTH + $clog2(MAX_SAMPLES) + 1)
                         + 5 * $clog2(MAX_SAMPLES + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [INW-1:0]   req_tdata,   // genotype_a, genotype_b, phenotype, zero pad
   input  logic             req_tlast,   // last_sample
   input  logic             q_full,
   output logic             q_push,
   output logic [SNAPW-1:0] q_data
);
   import tla_pkg::*;

   localparam int CNTW = $clog2(MAX_SAMPLES + 1);
   localparam int SUMW = PHENO_WIDTH + $clog2(MAX_SAMPLES) + 1;

   logic signed [SUMW-1:0] sums_ff [NUM_GROUPS];
   logic signed [SUMW-1:0] sums_in [NUM_GROUPS];
   logic signed [SUMW-1:0] acc_sums [NUM_GROUPS];
   logic [CNTW-1:0] cnts_ff [NUM_GROUPS];
   logic [CNTW-1:0] cnts_in [NUM_GROUPS];
   logic [CNTW-1:0] acc_cnts [NUM_GROUPS];
   logic [CNTW-1:0] scnt_ff, scnt_in, acc_scnt;
   logic [GRPW-1:0] grp;
   logic [PHENO_WIDTH-1:0] pheno;
   logic accept, room;

   assign req_tready = !q_full;
   assign accept = req_tvalid && req_tready;
   assign grp = {~req_tdata[0], ~req_tdata[1]};
   assign pheno = req_tdata[PHENO_WIDTH+1:2];
   assign room = scnt_ff < CNTW'(MAX_SAMPLES);
   assign q_push = accept && req_tlast;

   // accumulate the sample, then clear after a last one
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         acc_sums[g] = sums_ff[g];
         acc_cnts[g] = cnts_ff[g];
      end
      acc_scnt = scnt_ff;
      if (accept && room) begin
         acc_sums[grp] = sums_ff[grp]
                       + {{(SUMW-PHENO_WIDTH){pheno[PHENO_WIDTH-1]}}, pheno};
         acc_cnts[grp] = cnts_ff[grp] + 1'b1;
         acc_scnt = scnt_ff + 1'b1;
      end
      for (int g = 0; g < NUM_GROUPS; g++) begin
         sums_in[g] = q_push ? '0 : acc_sums[g];
         cnts_in[g] = q_push ? '0 : acc_cnts[g];
      end
      scnt_in = q_push ? '0 : acc_scnt;
   end

   // snapshot: sums, then counts, then total count
   always_comb begin
      q_data = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         q_data[g*SUMW +: SUMW] = acc_sums[g];
         q_data[NUM_GROUPS*SUMW + g*CNTW +: CNTW] = acc_cnts[g];
      end
      q_data[NUM_GROUPS*(SUMW+CNTW) +: CNTW] = acc_scnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            sums_ff[g] <= '0;
            cnts_ff[g] <= '0;
         end
         scnt_ff <= '0;
      end else begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            sums_ff[g] <= sums_in[g];
            cnts_ff[g] <= cnts_in[g];
         end
         scnt_ff <= scnt_in;
      end
   end

endmodule

@@ hdl/tla_queue.sv @@
// Two-entry queue of group snapshots between the front and back ends.
// No package dependency.
module tla_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             nonempty
);
   logic [WIDTH-1:0] entries_ff [2];
   logic wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full = cnt_ff == 2'd2;
   assign nonempty = cnt_ff != 2'd0;
   assign pop_data = entries_ff[rd_ff];

   always_comb begin
      wr_in = push ? ~wr_ff : wr_ff;
      rd_in = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ hdl/tla_back.sv @@
// Back end: turns one group snapshot into the F statistic with a shared
// shift-add multiplier and a restoring divider, then holds the result. Uses tla_pkg.
module tla_back #(
   parameter int MAX_SAMPLES = tla_pkg::DEF_MAX_SAMPLES,
   parameter int PHENO_WIDTH = tla_pkg::DEF_PHENO_WIDTH,
   parameter int SNAPW = 4 * (PHENO_WIDTH + $clog2(MAX_SAMPLES) + 1)
                         + 5 * $clog2(MAX_SAMPLES + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_nonempty,
   input  logic [SNAPW-1:0]          q_data,
   output logic                      q_pop,
   input  logic [tla_pkg::REGW-1:0]  total_ss,
   input  logic [tla_pkg::REGW-1:0]  mean_corr,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [tla_pkg::RSPW-1:0]  rsp_tdata
);
   import tla_pkg::*;

   localparam int CNTW = $clog2(MAX_SAMPLES + 1);
   localparam int SUMW = PHENO_WIDTH + $clog2(MAX_SAMPLES) + 1;
   localparam int MAW  = SUMW;
   localparam int SQW  = 2 * MAW;
   localparam int MBW  = (MAW > SMW) ? MAW : SMW;
   localparam int PRW  = MAW + MBW;
   localparam int NUMW = CNTW + SMW + FRACW;
   localparam int NW   = (SQW > NUMW) ? SQW : NUMW;
   localparam int DW   = (CNTW > DENW) ? CNTW : DENW;
   localparam int STW  = $clog2(NW + 1);

   back_state_type state_ff, state_in;

   logic signed [SUMW-1:0] sums_ff [NUM_GROUPS];
   logic signed [SUMW-1:0] sums_in [NUM_GROUPS];
   logic [CNTW-1:0] cnts_ff [NUM_GROUPS];
   logic [CNTW-1:0] cnts_in [NUM_GROUPS];
   logic [CNTW-1:0] scnt_ff, scnt_in;
   logic [GRPW-1:0] grp_ff, grp_in;
   logic ph_ff, ph_in, empty_ff, empty_in;
   logic [RAWW-1:0] raw_ff, raw_in;
   logic [SSBW-1:0] ssb_ff, ssb_in;
   logic [DENDW-1:0] dend_ff, dend_in;
   logic signed [CNTW:0] df2_ff, df2_in;
   logic [PRW-1:0] mcand_ff, mcand_in, macc_ff, macc_in;
   logic [MAW-1:0] mplier_ff, mplier_in;
   logic [STW-1:0] step_ff, step_in;
   logic [DW-1:0] rem_ff, rem_in, dvsr_ff, dvsr_in;
   logic [NW-1:0] dnum_ff, dnum_in, quo_ff, quo_in;
   logic [SMW-1:0] dm_ff, dm_in;
   logic [DENW-1:0] den_ff, den_in;
   logic [DFBW-1:0] dfb_ff, dfb_in;
   logic [DFWW-1:0] dfw_ff, dfw_in;
   logic [FW-1:0] f_ff, f_in;
   logic sat_ff, sat_in;
   logic out_valid_ff, out_valid_in;
   logic [RSPW-1:0] out_data_ff, out_data_in;

   // shared datapath terms
   logic signed [SUMW-1:0] cur_sum;
   logic [MAW-1:0] cur_mag;
   logic [DW:0] rem_sh;
   logic div_ge;
   logic [RAWW-1:0] term;
   logic [RAWW:0] raw_sum;
   logic [2:0] df1;
   logic neg, ok, out_free;
   logic [NW-1:0] num_w;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign out_free = !out_valid_ff || rsp_tready;

   assign cur_sum = sums_ff[grp_ff];
   assign cur_mag = MAW'(cur_sum[SUMW-1] ? -cur_sum : cur_sum);
   assign rem_sh = {rem_ff, dnum_ff[NW-1]};
   assign div_ge = rem_sh >= {1'b0, dvsr_ff};
   assign term = (quo_ff > NW'(SSB_LIMIT)) ? SSB_LIMIT : quo_ff[RAWW-1:0];
   assign raw_sum = {1'b0, raw_ff} + {1'b0, term};
   assign df1 = empty_ff ? 3'd3 : 3'd4;
   assign neg = ssb_ff[SSBW-1] ^ dend_ff[DENDW-1] ^ df2_ff[CNTW];
   assign ok = (ssb_ff != '0) && (dend_ff != '0) && (df2_ff != '0) && !neg;
   assign num_w = NW'(macc_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (q_nonempty) state_in = ST_GROUP;
         ST_GROUP: begin
            if (cnts_ff[grp_ff] == '0) begin
               state_in = (grp_ff == GRPW'(NUM_GROUPS - 1)) ? ST_SSB : ST_GROUP;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (step_ff == STW'(MAW - 1)) state_in = ph_ff ? ST_DEN : ST_DIVLD;
         end
         ST_DIVLD: state_in = ST_DIV;
         ST_DIV: begin
            if (step_ff == STW'(NW - 1)) state_in = ph_ff ? ST_FINAL : ST_ACC;
         end
         ST_ACC: begin
            state_in = (grp_ff == GRPW'(NUM_GROUPS - 1)) ? ST_SSB : ST_GROUP;
         end
         ST_SSB:   state_in = ST_RATIO;
         ST_RATIO: state_in = ST_SIGN;
         ST_SIGN:  state_in = ok ? ST_MUL : ST_EMIT;
         ST_DEN:   state_in = ST_SATCK;
         ST_SATCK: begin
            state_in = (num_w >= (NW'(den_ff) << FRACW)) ? ST_EMIT : ST_DIV;
         end
         ST_FINAL: state_in = ST_EMIT;
         ST_EMIT:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and handshake outputs
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         sums_in[g] = sums_ff[g];
         cnts_in[g] = cnts_ff[g];
      end
      scnt_in = scnt_ff;
      grp_in = grp_ff;
      ph_in = ph_ff;
      empty_in = empty_ff;
      raw_in = raw_ff;
      ssb_in = ssb_ff;
      dend_in = dend_ff;
      df2_in = df2_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      macc_in = macc_ff;
      step_in = step_ff;
      rem_in = rem_ff;
      dvsr_in = dvsr_ff;
      dnum_in = dnum_ff;
      quo_in = quo_ff;
      dm_in = dm_ff;
      den_in = den_ff;
      dfb_in = dfb_ff;
      dfw_in = dfw_ff;
      f_in = f_ff;
      sat_in = sat_ff;
      out_data_in = out_data_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      q_pop = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_nonempty) begin
               q_pop = 1'b1;
               for (int g = 0; g < NUM_GROUPS; g++) begin
                  sums_in[g] = q_data[g*SUMW +: SUMW];
                  cnts_in[g] = q_data[NUM_GROUPS*SUMW + g*CNTW +: CNTW];
               end
               scnt_in = q_data[NUM_GROUPS*(SUMW+CNTW) +: CNTW];
               grp_in = '0;
               ph_in = 1'b0;
               empty_in = 1'b0;
               raw_in = '0;
            end
         end
         ST_GROUP: begin
            if (cnts_ff[grp_ff] == '0) begin
               empty_in = 1'b1;
               grp_in = grp_ff + 1'b1;
            end else begin
               mcand_in = PRW'(cur_mag);
               mplier_in = cur_mag;
               macc_in = '0;
               step_in = '0;
            end
         end
         ST_MUL: begin
            macc_in = macc_ff + (mplier_ff[0] ? mcand_ff : '0);
            mcand_in = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in = step_ff + 1'b1;
         end
         ST_DIVLD: begin
            dnum_in = NW'(macc_ff[SQW-1:0]);
            dvsr_in = DW'(cnts_ff[grp_ff]);
            rem_in = '0;
            quo_in = '0;
            step_in = '0;
         end
         ST_DIV: begin
            rem_in = div_ge ? DW'(rem_sh - {1'b0, dvsr_ff}) : rem_sh[DW-1:0];
            dnum_in = dnum_ff << 1;
            quo_in = {quo_ff[NW-2:0], div_ge};
            step_in = step_ff + 1'b1;
         end
         ST_ACC: begin
            raw_in = (raw_sum > {1'b0, SSB_LIMIT}) ? SSB_LIMIT : raw_sum[RAWW-1:0];
            grp_in = grp_ff + 1'b1;
         end
         ST_SSB: begin
            ssb_in = SSBW'(raw_ff) - SSBW'(mean_corr);
         end
         ST_RATIO: begin
            dend_in = DENDW'(total_ss) - {ssb_ff[SSBW-1], ssb_ff};
            df2_in = $signed({1'b0, scnt_ff}) - $signed({{(CNTW-2){1'b0}}, df1});
            dfb_in = DFBW'(df1 - 3'd1);
         end
         ST_SIGN: begin
            if (df2_ff[CNTW]) begin
               dfw_in = '0;
            end else if (df2_ff > DFW_MAX) begin
               dfw_in = DFWW'(DFW_MAX);
            end else begin
               dfw_in = DFWW'(df2_ff);
            end
            f_in = '0;
            sat_in = 1'b0;
            dm_in = SMW'(dend_ff[DENDW-1] ? -dend_ff : dend_ff);
            mcand_in = PRW'(SMW'(ssb_ff[SSBW-1] ? -ssb_ff : ssb_ff));
            mplier_in = MAW'(CNTW'(df2_ff[CNTW] ? -df2_ff : df2_ff));
            macc_in = '0;
            step_in = '0;
            ph_in = 1'b1;
         end
         ST_DEN: begin
            den_in = {1'b0, dm_ff, 1'b0}
                   + ((dfb_ff == 2'd3) ? {2'b0, dm_ff} : '0);
         end
         ST_SATCK: begin
            if (num_w >= (NW'(den_ff) << FRACW)) begin
               f_in = '1;
               sat_in = 1'b1;
            end else begin
               dnum_in = num_w << FRACW;
               dvsr_in = DW'(den_ff);
               rem_in = '0;
               quo_in = '0;
               step_in = '0;
            end
         end
         ST_FINAL: begin
            f_in = quo_ff[FW-1:0];
            sat_in = 1'b0;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in = {sat_ff, dfw_ff, dfb_ff, f_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         sums_ff[g] <= sums_in[g];
         cnts_ff[g] <= cnts_in[g];
      end
      scnt_ff <= scnt_in;
      grp_ff <= grp_in;
      ph_ff <= ph_in;
      empty_ff <= empty_in;
      raw_ff <= raw_in;
      ssb_ff <= ssb_in;
      dend_ff <= dend_in;
      df2_ff <= df2_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      macc_ff <= macc_in;
      step_ff <= step_in;
      rem_ff <= rem_in;
      dvsr_ff <= dvsr_in;
      dnum_ff <= dnum_in;
      quo_ff <= quo_in;
      dm_ff <= dm_in;
      den_ff <= den_in;
      dfb_ff <= dfb_in;
      dfw_ff <= dfw_in;
      f_ff <= f_in;
      sat_ff <= sat_in;
      out_data_ff <= out_data_in;
   end

`ifndef SYNTHESIS
   a_sat_all_ones: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff[RSPW-1] |-> out_data_ff[FW-1:0] == '1)
      else $error("saturated result without full-scale f_value");

   a_dfb_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_data_ff[FW+DFBW-1:FW] == 2'd2
                    || out_data_ff[FW+DFBW-1:FW] == 2'd3)
      else $error("df_between out of range");

   a_raw_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACC |=> raw_ff <= SSB_LIMIT)
      else $error("group term sum exceeds limit");
`endif

endmodule

@@ hdl/two_locus_anova_f_statistic.sv @@
// Top level of the two-locus ANOVA F statistic block.
// Holds the configuration registers; depends on tla_pkg, tla_front,
// tla_queue and tla_back.
//
// Usage:
//  - req channel: one sample per transfer; tdata carries the genotype bits and
//    the signed phenotype, tlast marks the final sample of a set. Samples are
//    taken one per cycle while the snapshot queue has room.
//  - rsp channel: one result per set, after the last sample's transfer.
//  - csr port: csr_we writes csr_wdata to register csr_index (0 total sum of squares,
//    1 mean correction). The user writes only while the block is idle; it is not enforced.
//  - Per set, the back end uses a bit-serial multiplier over the group sum
//    width (29) and a restoring divider over the divider width (76).
//    Two finished sets can wait in the queue while the back end works.
//  - Reset clears the accumulators, the queue, the sequencer and the result
//    valid flag; configuration registers reset to zero.
//  - A stalled rsp holds its result; the back end waits at the output
//    register, the queue fills and then req_tready drops.
module two_locus_anova_f_statistic #(
   parameter int MAX_SAMPLES = tla_pkg::DEF_MAX_SAMPLES,
   parameter int PHENO_WIDTH = tla_pkg::DEF_PHENO_WIDTH,
   parameter int INW = ((PHENO_WIDTH + 2 + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [INW-1:0]            req_tdata,  // genotype_a, genotype_b, phenotype, pad
   input  logic                      req_tlast,  // last_sample
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [tla_pkg::RSPW-1:0]  rsp_tdata,  // f_value, df_between, df_within, saturated
   input  logic                      csr_we,
   input  logic [tla_pkg::CSRIW-1:0] csr_index,
   input  logic [tla_pkg::REGW-1:0]  csr_wdata
);
   import tla_pkg::*;

   localparam int SNAPW = 4 * (PHENO_WIDTH + $clog2(MAX_SAMPLES) + 1)
                          + 5 * $clog2(MAX_SAMPLES + 1);

   logic [REGW-1:0] tss_ff, tss_in, mc_ff, mc_in;
   logic q_full, q_push, q_pop, q_nonempty;
   logic [SNAPW-1:0] q_wdata, q_rdata;

   // configuration writes
   always_comb begin
      tss_in = tss_ff;
      mc_in = mc_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TOTAL_SS:  tss_in = csr_wdata;
            CSR_MEAN_CORR: mc_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tss_ff <= '0;
         mc_ff <= '0;
      end else begin
         tss_ff <= tss_in;
         mc_ff <= mc_in;
      end
   end

   tla_front #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .PHENO_WIDTH(PHENO_WIDTH),
      .INW(INW),
      .SNAPW(SNAPW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .q_full(q_full),
      .q_push(q_push),
      .q_data(q_wdata)
   );

   tla_queue #(
      .WIDTH(SNAPW)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(q_wdata),
      .pop(q_pop),
      .pop_data(q_rdata),
      .full(q_full),
      .nonempty(q_nonempty)
   );

   tla_back #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .PHENO_WIDTH(PHENO_WIDTH),
      .SNAPW(SNAPW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_nonempty(q_nonempty),
      .q_data(q_rdata),
      .q_pop(q_pop),
      .total_ss(tss_ff),
      .mean_corr(mc_ff),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

endmodule

@@ test/two_locus_anova_f_statistic_test.sv @@
// Self-checking bench for the two-locus ANOVA F statistic block.
// Streams sample sets, predicts the F result of each set and compares it on the rsp channel.
// Depends on tla_pkg and two_locus_anova_f_statistic.
module two_locus_anova_f_statistic_test;
   import tla_pkg::*;

   localparam int MAXS = 4096;
   localparam int INW = 24;
   localparam longint unsigned TERM_LIMIT = 64'h4000_0000_0000;
   localparam longint unsigned REG_MAX = 64'hFFF_FFFF_FFFF;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 1500;

   // kinds of sample set
   localparam int SET_RANDOM = 0;
   localparam int SET_EMPTY_GROUP = 1;
   localparam int SET_SINGLE = 2;
   localparam int SET_EXTREME = 3;

   // ways of choosing the registers against a set
   localparam int CFG_NORMAL = 0;
   localparam int CFG_EQUAL = 1;
   localparam int CFG_NEAR = 2;
   localparam int CFG_NEG = 3;
   localparam int CFG_ZERO_SSB = 4;
   localparam int CFG_WILD = 5;

   typedef struct {
      logic a;
      logic b;
      logic signed [15:0] pheno;
      logic last;
   } sample_type;

   typedef struct {
      logic [FW-1:0] f_value;
      logic [DFBW-1:0] df_between;
      logic [DFWW-1:0] df_within;
      logic saturated;
   } f_result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [INW-1:0] req_tdata = '0;
   logic req_tlast = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSPW-1:0] rsp_tdata;
   logic csr_we = 0;
   logic [CSRIW-1:0] csr_index = CSR_TOTAL_SS;
   logic [REGW-1:0] csr_wdata = '0;

   two_locus_anova_f_statistic DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   sample_type pending_samples[$];
   f_result_type expected_f[$];
   int errors = 0;
   int send_idle_pct = 19;
   int recv_idle_pct = 56;
   logic req_fire = 0;

   // predictor copy of the block state and registers
   longint grp_sum[4];
   int grp_cnt[4];
   int set_count = 0;
   longint unsigned tss_reg = 0;
   longint unsigned mc_reg = 0;

   // sum of floor(T*T/n) over non-empty groups, saturated
   function automatic longint unsigned group_terms(longint s[4], int n[4]);
      longint unsigned acc, mag, t;
      acc = 0;
      for (int k = 0; k < 4; k++) begin
         if (n[k] > 0) begin
            mag = (s[k] < 0) ? -s[k] : s[k];
            t = (mag * mag) / n[k];
            if (t > TERM_LIMIT) t = TERM_LIMIT;
            acc += t;
            if (acc > TERM_LIMIT) acc = TERM_LIMIT;
         end
      end
      return acc;
   endfunction

   // one accepted sample; on the last mark, predict the F result and clear
   task automatic take_sample(sample_type s);
      int g, df1, df2;
      longint unsigned raw, sm, dm, d2, num, den, q0;
      longint ssb, den_d;
      logic [127:0] wide;
      f_result_type r;
      g = (s.a ? 0 : 2) + (s.b ? 0 : 1);
      if (set_count < MAXS) begin
         grp_sum[g] += s.pheno;
         grp_cnt[g] += 1;
         set_count += 1;
      end
      if (!s.last) return;
      raw = group_terms(grp_sum, grp_cnt);
      df1 = 4;
      for (int k = 0; k < 4; k++) if (grp_cnt[k] == 0) df1 = 3;
      df2 = set_count - df1;
      df1 -= 1;
      ssb = longint'(raw) - longint'(mc_reg);
      den_d = longint'(tss_reg) - ssb;
      r.f_value = '0;
      r.saturated = 0;
      if (den_d != 0 && ssb != 0 && df2 != 0 &&
          !((ssb < 0) ^ (den_d < 0) ^ (df2 < 0))) begin
         sm = (ssb < 0) ? -ssb : ssb;
         dm = (den_d < 0) ? -den_d : den_d;
         d2 = (df2 < 0) ? -df2 : df2;
         num = d2 * sm;
         den = longint'(df1) * dm;
         q0 = num / den;
         if (q0 > 64'hFFFF) begin
            r.f_value = '1;
            r.saturated = 1;
         end else begin
            wide = {64'd0, num} << 16;
            wide = wide / {64'd0, den};
            r.f_value = wide[FW-1:0];
         end
      end
      r.df_between = df1[DFBW-1:0];
      r.df_within = (df2 < 0) ? '0 : (df2 > DFW_MAX) ? DFWW'(DFW_MAX) : DFWW'(df2);
      expected_f = {expected_f, r};
      for (int k = 0; k < 4; k++) begin
         grp_sum[k] = 0;
         grp_cnt[k] = 0;
      end
      set_count = 0;
   endtask

   // acceptance flag for the driver
   always @(posedge clock) req_fire <= req_tvalid && req_tready;

   // sample driver
   always @(negedge clock) begin
      if (req_tvalid && !req_fire) begin
         req_tvalid <= 1;
      end else if (!reset && pending_samples.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
         sample_type s;
         s = pending_samples.pop_front();
         req_tvalid <= 1;
         req_tdata <= {6'd0, s.pheno, s.b, s.a};
         req_tlast <= s.last;
      end else begin
         req_tvalid <= 0;
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor: predict on sample transfers, check result transfers
   int stall_cycles = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sample_type s;
            s.a = req_tdata[0];
            s.b = req_tdata[1];
            s.pheno = req_tdata[17:2];
            s.last = req_tlast;
            take_sample(s);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_f.size() == 0) begin
               $error("result transfer with no result expected: %h", rsp_tdata);
               errors++;
            end else begin
               f_result_type e;
               e = expected_f.pop_front();
               if (rsp_tdata[31:0] !== e.f_value) begin
                  $error("f_value expected %h got %h", e.f_value, rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[33:32] !== e.df_between) begin
                  $error("df_between expected %0d got %0d", e.df_between, rsp_tdata[33:32]);
                  errors++;
               end
               if (rsp_tdata[46:34] !== e.df_within) begin
                  $error("df_within expected %0d got %0d", e.df_within, rsp_tdata[46:34]);
                  errors++;
               end
               if (rsp_tdata[47] !== e.saturated) begin
                  $error("saturated expected %0d got %0d", e.saturated, rsp_tdata[47]);
                  errors++;
               end
            end
         end
      end
      // watchdog on cycles without any transfer
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // wait until every sample is sent and every result is back
   task automatic wait_idle();
      while (pending_samples.size() > 0 || req_tvalid || expected_f.size() > 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSRIW-1:0] idx, longint unsigned v);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v[REGW-1:0];
      if (idx == CSR_TOTAL_SS) tss_reg = v & REG_MAX;
      else mc_reg = v & REG_MAX;
      @(negedge clock);
      csr_we <= 0;
   endtask

   function automatic logic signed [15:0] rand_pheno();
      case ($urandom_range(3))
         0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         1: return $signed(16'($urandom_range(255))) - 16'sd128;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic longint unsigned rand_reg();
      longint unsigned v;
      v = {$urandom, $urandom};
      return v & REG_MAX;
   endfunction

   // build one set, optionally retune the registers against it, then queue it
   task automatic run_set(int n, int kind, int cfg_kind, bit write_cfg);
      sample_type items[$];
      sample_type s;
      longint s4[4];
      int n4[4];
      int hole, g;
      longint unsigned raw, mc, tss, ssb;
      hole = $urandom_range(3);
      for (int k = 0; k < 4; k++) begin
         s4[k] = 0;
         n4[k] = 0;
      end
      for (int i = 0; i < n; i++) begin
         g = $urandom_range(3);
         if (kind == SET_EMPTY_GROUP && g == hole) g = (g + 1) % 4;
         if (kind == SET_EXTREME) g = i % 4;
         s.a = (g < 2);
         s.b = (g % 2 == 0);
         s.pheno = (kind == SET_EXTREME) ? ((i / 4) % 2 ? 16'sh7FFF : 16'sh8000)
                                         : rand_pheno();
         s.last = (i == n - 1);
         if (i < MAXS) begin
            s4[g] += s.pheno;
            n4[g] += 1;
         end
         items = {items, s};
      end
      if (write_cfg) begin
         raw = group_terms(s4, n4);
         mc = (raw == 0) ? 0 : {$urandom, $urandom} % (raw + 1);
         ssb = raw - mc;
         case (cfg_kind)
            CFG_EQUAL: tss = ssb;
            CFG_NEAR: tss = ssb + 1;
            CFG_NEG: begin
               mc = raw + 1 + $urandom_range(1000);
               tss = rand_reg();
            end
            CFG_ZERO_SSB: begin
               mc = raw;
               tss = rand_reg();
            end
            CFG_WILD: begin
               mc = $urandom_range(1) ? REG_MAX : rand_reg();
               tss = $urandom_range(1) ? REG_MAX : rand_reg();
            end
            default: tss = ssb * $urandom_range(1, 8) + $urandom_range(65535);
         endcase
         if (mc > REG_MAX) mc = REG_MAX;
         if (tss > REG_MAX) tss = REG_MAX;
         wait_idle();
         write_reg(CSR_TOTAL_SS, tss);
         write_reg(CSR_MEAN_CORR, mc);
      end
      foreach (items[i]) pending_samples = {pending_samples, items[i]};
   endtask

   // stimulus
   initial begin
      for (int k = 0; k < 4; k++) begin
         grp_sum[k] = 0;
         grp_cnt[k] = 0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: register extremes and special cases
      write_reg(CSR_TOTAL_SS, REG_MAX);
      write_reg(CSR_MEAN_CORR, 0);
      run_set(8, SET_EXTREME, CFG_NORMAL, 0);
      run_set(1, SET_SINGLE, CFG_NORMAL, 1);
      run_set(2, SET_RANDOM, CFG_NORMAL, 1);
      run_set(6, SET_EMPTY_GROUP, CFG_NORMAL, 1);
      run_set(5, SET_RANDOM, CFG_EQUAL, 1);
      run_set(6, SET_RANDOM, CFG_NEAR, 1);
      run_set(5, SET_RANDOM, CFG_NEG, 1);
      run_set(4, SET_RANDOM, CFG_ZERO_SSB, 1);
      run_set(4, SET_EXTREME, CFG_WILD, 1);

      // random sets over three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         wait_idle();
         send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 56 : 0;
         recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 19 : 0;
         for (int done = 0; done < 120; ) begin
            int n;
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
            run_set(n, ($urandom_range(3) == 0) ? SET_EMPTY_GROUP : SET_RANDOM,
                    $urandom_range(CFG_WILD), $urandom_range(3) == 0);
            done += n;
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_f.size() > 0) begin
         $error("%0d results never arrived", expected_f.size());
         errors++;
      end
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/tla_pkg.sv
hdl/tla_front.sv
hdl/tla_queue.sv
hdl/tla_back.sv
hdl/two_locus_anova_f_statistic.sv
test/two_locus_anova_f_statistic_test.sv
